[rtl/sfra_pkg.sv]
package sfra_pkg;

	localparam logic [1:0] OP_RX     = 2'd0;
	localparam logic [1:0] OP_LWRITE = 2'd1;
	localparam logic [1:0] OP_LREAD  = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_HEADER   = 3'd1;
	localparam logic [2:0] ST_CHECKSUM = 3'd2;
	localparam logic [2:0] ST_ID       = 3'd3;
	localparam logic [2:0] ST_COMMAND  = 3'd4;
	localparam logic [2:0] ST_LENGTH   = 3'd5;

	localparam logic [1:0] REG_CMD_WQ   = 2'd0;
	localparam logic [1:0] REG_CMD_WA   = 2'd1;
	localparam logic [1:0] REG_CMD_READ = 2'd2;

	localparam logic [7:0] RST_CMD_WQ   = 8'h01;
	localparam logic [7:0] RST_CMD_WA   = 8'h02;
	localparam logic [7:0] RST_CMD_READ = 8'h03;

	localparam logic [7:0] SYNC0    = 8'h55;
	localparam logic [7:0] SYNC1    = 8'hAA;
	localparam logic [7:0] BCAST_ID = 8'hFF;
	localparam logic [7:0] ACK_LEN  = 8'h03;
	localparam logic [7:0] ACK_DATA = 8'h01;

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_LREAD    = 8'b0000_0010,
		S_SCAN     = 8'b0000_0100,
		S_SCAN_END = 8'b0000_1000,
		S_EVAL     = 8'b0001_0000,
		S_WSWEEP   = 8'b0010_0000,
		S_WEND     = 8'b0100_0000,
		S_TX       = 8'b1000_0000
	} state_t;

	function automatic logic [15:0] def_word(input logic [8:0] a);
		logic [15:0] v;
		case (a)
			9'h001: v = 16'h00FD;
			9'h002: v = 16'h0002;
			9'h003: v = 16'h0101;
			9'h007: v = 16'h0001;
			9'h008: v = 16'h0002;
			9'h00A: v = 16'h0001;
			9'h051: v = 16'h0003;
			9'h057: v = 16'h0002;
			9'h058: v = 16'h0002;
			default: v = 16'h0000;
		endcase
		return v;
	endfunction

endpackage

[rtl/serial_frame_register_access_core.sv]
// Serial frame register access core.
// Items enter on start while busy is low: opcode 0 is a received frame byte
// (frame_end marks the checksum byte), 1 a local word write, 2 a local read.
// Results appear on done with tx_valid/tx_byte/last/status/read_value; last
// marks the final result of an item. The receiver cannot stall, so results
// are never held.
// A frame byte without frame_end, and a local write, give no result and keep
// busy low. A local read passes through S_LREAD and its result is registered.
// At frame end the frame buffer memory is swept once, then a write sweeps the
// data bytes (one per cycle) into the word store with byte writes, filling the
// other byte of a never-written word with its default; responses go out one
// byte a cycle, but each read data byte waits for its own store read.
// Reset clears the byte count, the command registers to 1/2/3, and marks
// every store word as holding its default value; no clearing pass is needed.
// Command registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, which the block itself does not enforce.
module serial_frame_register_access_core #(
	parameter int STORE_WORDS = 96,
	parameter int FRAME_BYTES = 64,
	parameter int READ_MAX    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	input  logic [6:0]  word_index,
	input  logic [15:0] word_value,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        done,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        last,
	output logic [2:0]  status,
	output logic [15:0] read_value
);
	import sfra_pkg::*;

	localparam int CW = $clog2(FRAME_BYTES + 1);
	localparam int FA = $clog2(FRAME_BYTES);
	localparam int AW = $clog2(STORE_WORDS);
	localparam int KW = $clog2(READ_MAX + 9);

	state_t state_q;
	logic [7:0] cmd_wq_q, cmd_wa_q, cmd_rd_q;

	logic [CW-1:0] cnt_q, n_q, ptr_q, sp_s1;
	logic          ovf_q, sv_s1, wmode_q, ack_q, have_q;
	logic [7:0]    lastb_q, b0_q, b1_q, len_q, id_q, cmd_q, idx_q, d0_q, sum_q, cs_q;
	logic [KW-1:0] k_q, total_q;

	logic [7:0]    fmem [FRAME_BYTES];
	logic [7:0]    fs_rd_s1;
	logic          fs_we, fs_iss;

	logic [15:0]   rmem [STORE_WORDS];
	logic [STORE_WORDS-1:0] vld_q;
	logic [15:0]   rs_rd_s1, rs_val, rs_wd, dw;
	logic [AW-1:0] rs_ra, rs_ra_s1, rs_wa;
	logic          rs_we, rs_full, rs_hi, rd_inr, rd_hi, rinr_s1, rhi_s1, rvld_s1;

	logic          acc;
	logic [8:0]    wi9;
	logic [9:0]    wb_addr, tb_addr;
	logic [CW-1:0] n_nx;
	logic          ovf_nx, is_data, lastk;
	logic [7:0]    tb, rbyte;

	logic          done_q, tx_valid_q, last_q;
	logic [7:0]    tx_byte_q;
	logic [2:0]    status_q;
	logic [15:0]   read_value_q;

	assign busy = (state_q != S_IDLE);
	assign acc = start & ~busy;
	assign wi9 = {2'b00, word_index};
	assign wb_addr = {1'b0, idx_q, 1'b0} + 10'(sp_s1) - 10'd6;
	assign tb_addr = {1'b0, idx_q, 1'b0} + 10'(k_q) - 10'd6;
	assign fs_we = (state_q == S_IDLE) && acc && (opcode == OP_RX) &&
		(cnt_q < CW'(FRAME_BYTES));
	assign fs_iss = ((state_q == S_SCAN) || (state_q == S_WSWEEP)) && (ptr_q != n_q - CW'(1));
	assign ovf_nx = ovf_q | ~(cnt_q < CW'(FRAME_BYTES));
	assign n_nx = (cnt_q < CW'(FRAME_BYTES)) ? cnt_q + CW'(1) : cnt_q;
	assign rs_val = rvld_s1 ? rs_rd_s1 : def_word(9'(rs_ra_s1));
	assign rbyte = rinr_s1 ? (rhi_s1 ? rs_val[15:8] : rs_val[7:0]) : 8'h00;
	assign lastk = (k_q == total_q - KW'(1));
	assign is_data = !ack_q && (k_q >= KW'(6)) && !lastk;

	always_comb begin
		if (k_q == KW'(0))
			tb = SYNC0;
		else if (k_q == KW'(1))
			tb = SYNC1;
		else if (k_q == KW'(2))
			tb = ack_q ? ACK_LEN : 8'(d0_q + 8'd2);
		else if (k_q == KW'(3))
			tb = id_q;
		else if (k_q == KW'(4))
			tb = cmd_q;
		else if (k_q == KW'(5))
			tb = idx_q;
		else if (lastk)
			tb = cs_q;
		else
			tb = ack_q ? ACK_DATA : rbyte;
	end

	always_comb begin
		rs_ra = '0;
		rd_inr = 1'b0;
		rd_hi = 1'b0;
		case (state_q)
			S_IDLE: begin
				rs_ra = wi9[AW-1:0];
				rd_inr = wi9 < 9'(STORE_WORDS);
			end
			S_SCAN_END: begin
				rs_ra = AW'(1);
				rd_inr = 1'b1;
			end
			S_TX: begin
				rs_ra = tb_addr[AW:1];
				rd_inr = tb_addr[9:1] < 9'(STORE_WORDS);
				rd_hi = tb_addr[0];
			end
			default: begin
				rs_ra = '0;
			end
		endcase
	end

	always_comb begin
		rs_we = 1'b0;
		rs_wa = '0;
		rs_full = 1'b1;
		rs_hi = 1'b0;
		rs_wd = word_value;
		dw = def_word(wb_addr[9:1]);
		if ((state_q == S_IDLE) && acc && (opcode == OP_LWRITE) &&
				(wi9 < 9'(STORE_WORDS))) begin
			rs_we = 1'b1;
			rs_wa = wi9[AW-1:0];
		end else if (sv_s1 && wmode_q && (wb_addr[9:1] < 9'(STORE_WORDS))) begin
			rs_we = 1'b1;
			rs_wa = wb_addr[AW:1];
			rs_full = ~vld_q[wb_addr[AW:1]];
			rs_hi = wb_addr[0];
			rs_wd = wb_addr[0] ? {fs_rd_s1, dw[7:0]} : {dw[15:8], fs_rd_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (fs_we)
			fmem[cnt_q[FA-1:0]] <= rx_byte;
		fs_rd_s1 <= fmem[ptr_q[FA-1:0]];
	end

	always_ff @(posedge clk) begin
		if (rs_we) begin
			if (rs_full)
				rmem[rs_wa] <= rs_wd;
			else if (rs_hi)
				rmem[rs_wa][15:8] <= rs_wd[15:8];
			else
				rmem[rs_wa][7:0] <= rs_wd[7:0];
		end
		rs_rd_s1 <= rmem[rs_ra];
		rs_ra_s1 <= rs_ra;
		rinr_s1 <= rd_inr;
		rhi_s1 <= rd_hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (rs_we)
				vld_q[rs_wa] <= 1'b1;
			rvld_s1 <= vld_q[rs_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_wq_q <= RST_CMD_WQ;
			cmd_wa_q <= RST_CMD_WA;
			cmd_rd_q <= RST_CMD_READ;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CMD_WQ:   cmd_wq_q <= cfg_data;
				REG_CMD_WA:   cmd_wa_q <= cfg_data;
				REG_CMD_READ: cmd_rd_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			n_q <= '0;
			ptr_q <= '0;
			sp_s1 <= '0;
			ovf_q <= 1'b0;
			sv_s1 <= 1'b0;
			wmode_q <= 1'b0;
			ack_q <= 1'b0;
			have_q <= 1'b0;
			lastb_q <= '0;
			b0_q <= '0;
			b1_q <= '0;
			len_q <= '0;
			id_q <= '0;
			cmd_q <= '0;
			idx_q <= '0;
			d0_q <= '0;
			sum_q <= '0;
			cs_q <= '0;
			k_q <= '0;
			total_q <= '0;
			done_q <= 1'b0;
			tx_valid_q <= 1'b0;
			tx_byte_q <= '0;
			last_q <= 1'b0;
			status_q <= ST_OK;
			read_value_q <= '0;
		end else begin
			done_q <= 1'b0;
			tx_valid_q <= 1'b0;
			tx_byte_q <= '0;
			last_q <= 1'b1;
			status_q <= ST_OK;
			read_value_q <= '0;
			sv_s1 <= fs_iss;
			sp_s1 <= ptr_q;

			if (sv_s1 && !wmode_q) begin
				if (sp_s1 == CW'(0)) b0_q <= fs_rd_s1;
				if (sp_s1 == CW'(1)) b1_q <= fs_rd_s1;
				if (sp_s1 == CW'(2)) len_q <= fs_rd_s1;
				if (sp_s1 == CW'(3)) id_q <= fs_rd_s1;
				if (sp_s1 == CW'(4)) cmd_q <= fs_rd_s1;
				if (sp_s1 == CW'(5)) idx_q <= fs_rd_s1;
				if (sp_s1 == CW'(6)) d0_q <= fs_rd_s1;
				if (sp_s1 >= CW'(2)) sum_q <= sum_q + fs_rd_s1;
			end

			case (state_q)
				S_IDLE: begin
					if (acc && (opcode == OP_RX)) begin
						lastb_q <= rx_byte;
						cnt_q <= n_nx;
						ovf_q <= ovf_nx;
						if (frame_end) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
							if (ovf_nx || (n_nx < CW'(7))) begin
								done_q <= 1'b1;
								status_q <= ST_LENGTH;
							end else begin
								n_q <= n_nx;
								ptr_q <= '0;
								sum_q <= '0;
								wmode_q <= 1'b0;
								state_q <= S_SCAN;
							end
						end
					end else if (acc && (opcode == OP_LREAD)) begin
						state_q <= S_LREAD;
					end
				end
				S_LREAD: begin
					done_q <= 1'b1;
					read_value_q <= rinr_s1 ? rs_val : 16'h0000;
					state_q <= S_IDLE;
				end
				S_SCAN, S_WSWEEP: begin
					if (fs_iss)
						ptr_q <= ptr_q + CW'(1);
					else
						state_q <= (state_q == S_SCAN) ? S_SCAN_END : S_WEND;
				end
				S_SCAN_END: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_IDLE;
					if ((b0_q != SYNC0) || (b1_q != SYNC1)) begin
						done_q <= 1'b1;
						status_q <= ST_HEADER;
					end else if ({2'b00, len_q} + 10'd5 != 10'(n_q)) begin
						done_q <= 1'b1;
						status_q <= ST_LENGTH;
					end else if (sum_q != lastb_q) begin
						done_q <= 1'b1;
						status_q <= ST_CHECKSUM;
					end else if ((id_q != BCAST_ID) && ({8'h00, id_q} != rs_val)) begin
						done_q <= 1'b1;
						status_q <= ST_ID;
					end else if ((cmd_q == cmd_wq_q) || (cmd_q == cmd_wa_q)) begin
						ack_q <= (cmd_q != cmd_wq_q);
						wmode_q <= 1'b1;
						ptr_q <= CW'(6);
						state_q <= S_WSWEEP;
					end else if (cmd_q == cmd_rd_q) begin
						if ((len_q < 8'd3) || ({1'b0, d0_q} > 9'(READ_MAX))) begin
							done_q <= 1'b1;
							status_q <= ST_LENGTH;
						end else begin
							ack_q <= 1'b0;
							k_q <= '0;
							cs_q <= '0;
							have_q <= 1'b0;
							total_q <= KW'(d0_q) + KW'(7);
							state_q <= S_TX;
						end
					end else begin
						done_q <= 1'b1;
						status_q <= ST_COMMAND;
					end
				end
				S_WEND: begin
					wmode_q <= 1'b0;
					if (!ack_q) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						k_q <= '0;
						cs_q <= '0;
						have_q <= 1'b0;
						total_q <= KW'(8);
						state_q <= S_TX;
					end
				end
				S_TX: begin
					if (is_data && !have_q) begin
						have_q <= 1'b1;
					end else begin
						have_q <= 1'b0;
						done_q <= 1'b1;
						tx_valid_q <= 1'b1;
						tx_byte_q <= tb;
						last_q <= lastk;
						k_q <= k_q + KW'(1);
						if ((k_q >= KW'(2)) && !lastk)
							cs_q <= cs_q + tb;
						if (lastk)
							state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign tx_valid = tx_valid_q;
	assign tx_byte = tx_byte_q;
	assign last = last_q;
	assign status = status_q;
	assign read_value = read_value_q;

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !tx_valid) |-> last)
		else $error("non-response result without last");
	a_tx_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && tx_valid) |-> (status == ST_OK && read_value == 16'h0000))
		else $error("response byte with status or read data");
	a_lwrite_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_LWRITE) |=> (!busy && !done))
		else $error("local write did not finish in one cycle");
	a_tx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && tx_valid && !last) |-> busy)
		else $error("idle during response frame");

endmodule

[tb/sfra_frame_checker.sv]
`timescale 1ns / 100ps

module sfra_frame_checker
	import sfra_pkg::*;
#(
	parameter int STORE_WORDS = 96,
	parameter int FRAME_BYTES = 64,
	parameter int READ_MAX    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  opcode,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	input  logic [6:0]  word_index,
	input  logic [15:0] word_value,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        done,
	input  logic        tx_valid,
	input  logic [7:0]  tx_byte,
	input  logic        last,
	input  logic [2:0]  status,
	input  logic [15:0] read_value,
	output int          fail_count,
	output int          pending_count
);

	typedef struct packed {
		logic        valid;
		logic [7:0]  data;
		logic        last;
		logic [2:0]  status;
		logic [15:0] rvalue;
	} tx_result_t;

	tx_result_t  expected_q[$];
	logic [15:0] words[STORE_WORDS];
	logic [7:0]  frame_buf[FRAME_BYTES];
	int          nbytes;
	bit          overflow;
	logic [7:0]  code_wq, code_wa, code_rd;

	assign pending_count = expected_q.size();

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic tx_result_t mk(input logic v, input logic [7:0] b, input logic l,
			input logic [2:0] st, input logic [15:0] rv);
		tx_result_t r;
		r.valid = v; r.data = b; r.last = l; r.status = st; r.rvalue = rv;
		return r;
	endfunction

	task automatic push_status(input logic [2:0] st);
		expected_q.push_back(mk(1'b0, 8'h00, 1'b1, st, 16'h0000));
	endtask

	function automatic logic [7:0] byte_at(input int addr);
		if ((addr >> 1) >= STORE_WORDS)
			return 8'h00;
		return (addr & 1) ? words[addr >> 1][15:8] : words[addr >> 1][7:0];
	endfunction

	task automatic byte_put(input int addr, input logic [7:0] v);
		if ((addr >> 1) < STORE_WORDS) begin
			if (addr & 1)
				words[addr >> 1][15:8] = v;
			else
				words[addr >> 1][7:0] = v;
		end
	endtask

	task automatic emit_bytes(input logic [7:0] q[$]);
		for (int i = 0; i < q.size(); i++)
			expected_q.push_back(mk(1'b1, q[i], i == q.size() - 1, ST_OK, 16'h0000));
	endtask

	task automatic evaluate_frame();
		int         len, cnt, base;
		logic [7:0] sum, id, cmd, idx, cs;
		logic [7:0] resp[$];
		if (overflow || nbytes < 7) begin
			push_status(ST_LENGTH);
			return;
		end
		if (frame_buf[0] != SYNC0 || frame_buf[1] != SYNC1) begin
			push_status(ST_HEADER);
			return;
		end
		len = frame_buf[2];
		if (nbytes != len + 5) begin
			push_status(ST_LENGTH);
			return;
		end
		sum = 8'h00;
		for (int i = 0; i < len + 2; i++)
			sum += frame_buf[2 + i];
		if (sum != frame_buf[nbytes - 1]) begin
			push_status(ST_CHECKSUM);
			return;
		end
		id = frame_buf[3];
		if (id != BCAST_ID && {8'h00, id} != words[1]) begin
			push_status(ST_ID);
			return;
		end
		cmd  = frame_buf[4];
		idx  = frame_buf[5];
		base = 2 * idx;
		if (cmd == code_wq || cmd == code_wa) begin
			for (int i = 0; i < len - 2; i++)
				byte_put(base + i, frame_buf[6 + i]);
			if (cmd == code_wq)
				push_status(ST_OK);
			else begin
				resp = '{SYNC0, SYNC1, ACK_LEN, id, cmd, idx, ACK_DATA,
					ACK_LEN + id + cmd + idx + ACK_DATA};
				emit_bytes(resp);
			end
			return;
		end
		if (cmd == code_rd) begin
			if (len < 3 || frame_buf[6] > READ_MAX) begin
				push_status(ST_LENGTH);
				return;
			end
			cnt  = frame_buf[6];
			resp = '{SYNC0, SYNC1, 8'(2 + cnt), id, cmd, idx};
			for (int i = 0; i < cnt; i++)
				resp.push_back(byte_at(base + i));
			cs = 8'h00;
			for (int i = 2; i < resp.size(); i++)
				cs += resp[i];
			resp.push_back(cs);
			emit_bytes(resp);
			return;
		end
		push_status(ST_COMMAND);
	endtask

	always @(posedge clk or negedge arst_n) begin
		tx_result_t e;
		if (!arst_n) begin
			expected_q.delete();
			fail_count = 0;
			nbytes     = 0;
			overflow   = 0;
			code_wq    = RST_CMD_WQ;
			code_wa    = RST_CMD_WA;
			code_rd    = RST_CMD_READ;
			foreach (words[i])
				words[i] = 16'h0000;
			words[1] = 16'h00FD; words[2] = 16'h0002; words[3] = 16'h0101;
			words[7] = 16'h0001; words[8] = 16'h0002; words[10] = 16'h0001;
			words[81] = 16'h0003; words[87] = 16'h0002; words[88] = 16'h0002;
		end else begin
			if (done) begin
				if (expected_q.size() == 0)
					report("result with none expected, tx_byte", tx_byte, 0);
				else begin
					e = expected_q.pop_front();
					if (tx_valid !== e.valid) report("tx_valid", tx_valid, e.valid);
					if (tx_byte !== e.data) report("tx_byte", tx_byte, e.data);
					if (last !== e.last) report("last", last, e.last);
					if (status !== e.status) report("status", status, e.status);
					if (read_value !== e.rvalue) report("read_value", read_value, e.rvalue);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_CMD_WQ:   code_wq = cfg_data;
					REG_CMD_WA:   code_wa = cfg_data;
					REG_CMD_READ: code_rd = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (opcode)
					OP_RX: begin
						if (nbytes < FRAME_BYTES) begin
							frame_buf[nbytes] = rx_byte;
							nbytes++;
						end else
							overflow = 1;
						if (frame_end) begin
							evaluate_frame();
							nbytes   = 0;
							overflow = 0;
						end
					end
					OP_LWRITE:
						if (word_index < STORE_WORDS)
							words[word_index] = word_value;
					OP_LREAD:
						expected_q.push_back(mk(1'b0, 8'h00, 1'b1, ST_OK,
							(word_index < STORE_WORDS) ? words[word_index] : 16'h0000));
					default: ;
				endcase
			end
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
	import sfra_pkg::*;

	localparam int READ_MAX  = 32;
	localparam int SETTLE    = 400;
	localparam int LIMIT     = 1000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [1:0]  opcode = OP_RX;
	logic [7:0]  rx_byte = 0;
	logic        frame_end = 0;
	logic [6:0]  word_index = 0;
	logic [15:0] word_value = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = REG_CMD_WQ;
	logic [7:0]  cfg_data = 0;
	logic        done, tx_valid, last;
	logic [7:0]  tx_byte;
	logic [2:0]  status;
	logic [15:0] read_value;
	int          fail_count, pending_count;
	int          cycles = 0;
	bit          no_idle = 0;
	logic [7:0]  cur_wq = RST_CMD_WQ, cur_wa = RST_CMD_WA, cur_rd = RST_CMD_READ;

	always #6 clk = ~clk;

	serial_frame_register_access_core i_dut (.*);

	sfra_frame_checker i_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL serial_frame_register_access_core");
			$finish;
		end
	end

	task automatic idle_burst();
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic fe,
			input logic [6:0] idx, input logic [15:0] val);
		idle_burst();
		start      <= 1;
		opcode     <= op;
		rx_byte    <= b;
		frame_end  <= fe;
		word_index <= idx;
		word_value <= val;
		do @(posedge clk); while (busy);
	endtask

	task automatic send_bytes(input logic [7:0] q[$]);
		foreach (q[i])
			send_item(OP_RX, q[i], i == q.size() - 1, 7'($urandom), 16'($urandom));
	endtask

	// fault: 0 clean, 1 bad sync, 2 bad checksum, 3 byte dropped, 4 byte added
	task automatic send_frame(input logic [7:0] id, input logic [7:0] cmd, input logic [7:0] idx,
			input logic [7:0] data[$], input int fault);
		logic [7:0] q[$];
		logic [7:0] sum;
		q   = '{SYNC0, SYNC1, 8'(data.size() + 2), id, cmd, idx};
		q   = {q, data};
		sum = 0;
		for (int i = 2; i < q.size(); i++)
			sum += q[i];
		q.push_back(sum);
		case (fault)
			1: q[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
			2: q[q.size() - 1] ^= 8'($urandom_range(1, 255));
			3: q.delete($urandom_range(0, q.size() - 2));
			4: q.insert($urandom_range(2, q.size() - 1), 8'($urandom));
			default: ;
		endcase
		send_bytes(q);
	endtask

	function automatic logic [7:0] rand_bytes_q(input int n, inout logic [7:0] q[$]);
		q = {};
		repeat (n) q.push_back(8'($urandom));
		return 0;
	endfunction

	task automatic settle();
		start <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cmds(input logic [7:0] wq, input logic [7:0] wa, input logic [7:0] rd);
		logic [7:0] v[3];
		v = '{wq, wa, rd};
		for (int i = 0; i < 3; i++) begin
			cfg_we    <= 1;
			cfg_index <= 2'(i);
			cfg_data  <= v[i];
			@(posedge clk);
		end
		cfg_we <= 0;
		@(posedge clk);
		cur_wq = wq; cur_wa = wa; cur_rd = rd;
	endtask

	task automatic random_item();
		int         r, n, fault;
		logic [7:0] d[$], cmd, id, idx, junk;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			idx = 8'($urandom_range(0, 127));
			if (idx == 1) idx = 0;
			send_item(OP_LWRITE, 8'($urandom), $urandom_range(0, 1), 7'(idx), 16'($urandom));
		end else if (r < 24)
			send_item(OP_LREAD, 8'($urandom), $urandom_range(0, 1), 7'($urandom), 16'($urandom));
		else if (r < 27) begin
			junk = rand_bytes_q($urandom_range(1, 10), d);
			send_bytes(d);
		end else if (r < 28)
			send_item(2'd3, 8'($urandom), $urandom_range(0, 1), 7'($urandom), 16'($urandom));
		else begin
			case ($urandom_range(0, 3))
				0: cmd = cur_wq;
				1: cmd = cur_wa;
				2: cmd = cur_rd;
				default: cmd = 8'($urandom);
			endcase
			r  = $urandom_range(0, 9);
			id = (r < 5) ? BCAST_ID : (r < 9) ? 8'hFD : 8'($urandom);
			idx = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(2, 255))
				: 8'($urandom_range(2, 100));
			if (cmd == cur_rd && cmd != cur_wq && cmd != cur_wa) begin
				n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 3);
				junk = rand_bytes_q(n, d);
				if (n > 0)
					d[0] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(READ_MAX + 1, 255))
						: 8'($urandom_range(0, READ_MAX));
			end else begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 62) : $urandom_range(0, 8);
				junk = rand_bytes_q(n, d);
			end
			fault = ($urandom_range(0, 99) < 85) ? 0 : $urandom_range(1, 4);
			send_frame(id, cmd, idx, d, fault);
		end
	endtask

	initial begin
		logic [7:0] d[$], junk;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_item(OP_LREAD, 8'h00, 0, 7'd0, 16'h0000);
		send_item(OP_LREAD, 8'hFF, 1, 7'd95, 16'hFFFF);
		send_item(OP_LWRITE, 8'h00, 0, 7'd95, 16'hFFFF);
		send_item(OP_LWRITE, 8'hFF, 1, 7'd127, 16'h1234);
		send_item(OP_LREAD, 8'h00, 0, 7'd127, 16'h0000);
		send_item(OP_LREAD, 8'h00, 0, 7'd95, 16'h0000);
		send_item(2'd3, 8'hFF, 1, 7'd127, 16'hFFFF);
		send_frame(8'hFD, cur_wq, 8'd4, '{8'h12, 8'h34}, 0);
		send_frame(BCAST_ID, cur_wa, 8'd95, '{8'hAB, 8'hCD, 8'hEF, 8'h01}, 0);
		send_frame(BCAST_ID, cur_rd, 8'd94, '{8'd8}, 0);
		send_frame(8'hFD, cur_rd, 8'd2, '{8'd32}, 0);
		send_frame(BCAST_ID, cur_rd, 8'd2, '{8'd33}, 0);
		send_frame(BCAST_ID, cur_rd, 8'd2, '{}, 0);
		send_frame(BCAST_ID, cur_wq, 8'd2, '{8'h01}, 1);
		send_frame(BCAST_ID, cur_wq, 8'd2, '{8'h01}, 2);
		send_frame(8'h00, cur_wq, 8'd2, '{8'h01}, 0);
		send_frame(BCAST_ID, 8'hEE, 8'd2, '{8'h01}, 0);
		junk = rand_bytes_q(66, d);
		send_bytes(d);
		send_item(OP_LWRITE, 8'h00, 0, 7'd1, 16'h0042);
		send_frame(8'h42, cur_rd, 8'd0, '{8'd4}, 0);
		send_item(OP_LWRITE, 8'h00, 0, 7'd1, 16'h00FD);
		send_frame(8'hFF, cur_wa, 8'd255, '{8'h00, 8'hFF}, 0);

		repeat (2) random_item();
		settle();
		write_cmds(8'h00, 8'hFF, 8'h80);
		repeat (1) random_item();
		settle();
		write_cmds(8'h07, 8'h07, 8'h07);
		repeat (1) random_item();
		settle();
		write_cmds(8'hFF, 8'h09, 8'h09);
		repeat (1) random_item();
		settle();
		write_cmds(8'h01, 8'h02, 8'h03);
		no_idle = 1;
		repeat (2) random_item();

		start <= 0;
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("PASS serial_frame_register_access_core");
		else
			$display("FAIL serial_frame_register_access_core");
		$finish;
	end

endmodule
